/* hdl/cba_pkg.sv */
`timescale 1ns / 1ps

package cba_pkg;

    localparam int NUM_BLOCKS = 128;
    localparam int NUM_LABELS = 26;

    localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int TAG_W  = 5;
    localparam int LABEL_W = 5;
    localparam int NEED_W  = 8;
    localparam int CMP_W   = (CNT_W > NEED_W) ? CNT_W : NEED_W;

    localparam int STATUS_W = 1;
    localparam int CLUS_W   = 7;
    localparam int FREED_W  = 8;
    localparam int REMAIN_W = 8;

    localparam logic [TAG_W-1:0] FREE_TAG = '0;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BLOCKS - 1);

    localparam logic [STATUS_W-1:0] STAT_DONE    = 1'b0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 1'b1;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_REPORT
    } state_t;

    // one write into the owner map
    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  data;
    } map_wr_t;

endpackage

/* hdl/cba_map.sv */
`timescale 1ns / 1ps

module cba_map
    import cba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TAG_W-1:0]  rd_data,
    input  map_wr_t           wr
);

    logic [TAG_W-1:0]  mem [NUM_BLOCKS];
    logic [TAG_W-1:0]  rdq_reg;
    logic [NUM_BLOCKS-1:0] vld_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdq_reg <= mem[rd_addr];
        end
    end

    // entries never written since reset read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rdq_reg : FREE_TAG;

endmodule

/* hdl/clustered_block_allocator.sv */
`timescale 1ns / 1ps
// First-fit block allocation map over NUM_BLOCKS blocks, each free or owned by a label.
// Input channel (in_valid / in_stall): command, file_label, blocks_needed.
//   Allocate gives the label to the lowest free blocks; refused when more are asked
//   than are free. Free releases every block of the label.
// Output channel (out_valid / out_stall): one word per input word with status,
//   cluster_count, freed_blocks and free_remaining.
// A command that scans the map reads, updates and writes back one map entry per cycle
//   through the owner RAM (one read and one write port), after the accept step and
//   before the drain and report steps.
// A refused allocate or an out-of-range label skips the scan: it goes from the accept
//   step straight to the report step.
// in_stall is high while a command is in progress. A finished result sits in the
//   output register; while the receiver stalls, the next command may still be taken
//   and scanned, and it waits in the report cycle until the register is emptied.
// Reset empties the output register and makes the whole map free with a free count of
//   NUM_BLOCKS at once; no clearing pass is needed.

module clustered_block_allocator
    import cba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [LABEL_W-1:0]  file_label,
    input  logic [NEED_W-1:0]   blocks_needed,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [CLUS_W-1:0]   cluster_count,
    output logic [FREED_W-1:0]  freed_blocks,
    output logic [REMAIN_W-1:0] free_remaining
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pipe_vld_reg;
    logic [ADDR_W-1:0]   pipe_idx_reg;
    cmd_t                cmd_reg, cmd_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    clus_reg, clus_next;
    logic [CNT_W-1:0]    freed_reg, freed_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic                run_open_reg, run_open_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CLUS_W-1:0]   cluster_count_reg, cluster_count_next;
    logic [FREED_W-1:0]  freed_blocks_reg, freed_blocks_next;
    logic [REMAIN_W-1:0] free_remaining_reg, free_remaining_next;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [TAG_W-1:0]    rd_data;
    map_wr_t             map_wr;
    logic                in_take;
    logic                entry_free;

    cba_map u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (map_wr)
    );

    assign in_take    = in_valid && (state_reg == S_IDLE);
    assign entry_free = (rd_data == FREE_TAG);

    always_comb
    begin
        state_next          = state_reg;
        rd_idx_next         = rd_idx_reg;
        cmd_next            = cmd_reg;
        tag_next            = tag_reg;
        left_next           = left_reg;
        clus_next           = clus_reg;
        freed_next          = freed_reg;
        free_cnt_next       = free_cnt_reg;
        run_open_next       = run_open_reg;
        stat_next           = stat_reg;
        out_valid_next      = out_valid_reg;
        status_next         = status_reg;
        cluster_count_next  = cluster_count_reg;
        freed_blocks_next   = freed_blocks_reg;
        free_remaining_next = free_remaining_reg;
        rd_en               = 1'b0;
        rd_addr             = rd_idx_reg;
        map_wr.en           = 1'b0;
        map_wr.addr         = pipe_idx_reg;
        map_wr.data         = FREE_TAG;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // entry read last cycle: modify and write back
        if (pipe_vld_reg)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                if (entry_free && (left_reg != '0))
                begin
                    map_wr.en     = 1'b1;
                    map_wr.data   = tag_reg;
                    left_next     = left_reg - 1'b1;
                    free_cnt_next = free_cnt_reg - 1'b1;
                    if (!run_open_reg)
                    begin
                        clus_next = clus_reg + 1'b1;
                    end
                    run_open_next = 1'b1;
                end
                else if (!entry_free)
                begin
                    run_open_next = 1'b0;
                end
            end
            else if (rd_data == tag_reg)
            begin
                map_wr.en     = 1'b1;
                map_wr.data   = FREE_TAG;
                freed_next    = freed_reg + 1'b1;
                free_cnt_next = free_cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd_next      = cmd_t'(command);
                    tag_next      = TAG_W'(file_label) + 1'b1;
                    left_next     = CNT_W'(blocks_needed);
                    clus_next     = '0;
                    freed_next    = '0;
                    run_open_next = 1'b0;
                    rd_idx_next   = '0;
                    stat_next     = STAT_DONE;
                    if (file_label >= LABEL_W'(NUM_LABELS))
                    begin
                        state_next = S_REPORT;
                    end
                    else if ((cmd_t'(command) == CMD_ALLOC) &&
                             (CMP_W'(blocks_needed) > CMP_W'(free_cnt_reg)))
                    begin
                        stat_next  = STAT_REFUSED;
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                if (rd_idx_reg == LAST_ADDR)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = stat_reg;
                    cluster_count_next  = CLUS_W'(clus_reg);
                    freed_blocks_next   = FREED_W'(freed_reg);
                    free_remaining_next = REMAIN_W'(free_cnt_reg);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            free_cnt_reg  <= CNT_W'(NUM_BLOCKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            pipe_vld_reg  <= rd_en;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg       <= rd_idx_reg;
        cmd_reg            <= cmd_next;
        tag_reg            <= tag_next;
        left_reg           <= left_next;
        clus_reg           <= clus_next;
        freed_reg          <= freed_next;
        run_open_reg       <= run_open_next;
        stat_reg           <= stat_next;
        status_reg         <= status_next;
        cluster_count_reg  <= cluster_count_next;
        freed_blocks_reg   <= freed_blocks_next;
        free_remaining_reg <= free_remaining_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign cluster_count  = cluster_count_reg;
    assign freed_blocks   = freed_blocks_reg;
    assign free_remaining = free_remaining_reg;

    a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= CNT_W'(NUM_BLOCKS))
        else $error("free count above map size");

    a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        map_wr.en |-> ($past(rd_en) && (map_wr.addr == $past(rd_addr))))
        else $error("map write not at the entry read the cycle before");

    a_drained_at_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |-> !pipe_vld_reg)
        else $error("report while a map entry is still in flight");

    a_alloc_writes_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (map_wr.en && (cmd_reg == CMD_ALLOC)) |-> (map_wr.data != FREE_TAG))
        else $error("allocate wrote a free entry");

    a_refused_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (stat_reg == STAT_DONE))
        else $error("scan running for a refused command");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cba_pkg::*;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [CLUS_W-1:0]   cluster_count;
        logic [FREED_W-1:0]  freed_blocks;
        logic [REMAIN_W-1:0] free_remaining;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [TAG_W-1:0] owner_tag [NUM_BLOCKS];
        int               free_cnt;
        alloc_result_t    pending[$];
        int               mismatches;
        int               checked;
        int               n_alloc;
        int               n_free;
        int               n_refused;
        int               n_zero;
        int               n_ignored;
        int               max_clusters;

        function new();
            foreach (owner_tag[i])
                owner_tag[i] = FREE_TAG;
            free_cnt     = NUM_BLOCKS;
            mismatches   = 0;
            checked      = 0;
            n_alloc      = 0;
            n_free       = 0;
            n_refused    = 0;
            n_zero       = 0;
            n_ignored    = 0;
            max_clusters = 0;
        endfunction

        // Update the block map for one accepted word and queue its expected result.
        function void note_command(cmd_t cmd, logic [LABEL_W-1:0] label,
                                   logic [NEED_W-1:0] need);
            alloc_result_t    r;
            logic [TAG_W-1:0] tag;
            int               left;
            int               clusters;
            int               freed;
            bit               in_run;

            r.status        = STAT_DONE;
            r.cluster_count = '0;
            r.freed_blocks  = '0;
            if (label >= NUM_LABELS)
            begin
                n_ignored++;
            end
            else
            begin
                tag = TAG_W'(label + 1);
                if (cmd == CMD_ALLOC)
                begin
                    n_alloc++;
                    if (need == 0)
                        n_zero++;
                    if (int'(need) > free_cnt)
                    begin
                        r.status = STAT_REFUSED;
                        n_refused++;
                    end
                    else
                    begin
                        left     = need;
                        clusters = 0;
                        in_run   = 1'b0;
                        for (int i = 0; i < NUM_BLOCKS && left != 0; i++)
                        begin
                            if (owner_tag[i] == FREE_TAG)
                            begin
                                owner_tag[i] = tag;
                                free_cnt--;
                                left--;
                                if (!in_run)
                                    clusters++;
                                in_run = 1'b1;
                            end
                            else
                            begin
                                in_run = 1'b0;
                            end
                        end
                        if (clusters > max_clusters)
                            max_clusters = clusters;
                        r.cluster_count = CLUS_W'(clusters);
                    end
                end
                else
                begin
                    n_free++;
                    freed = 0;
                    for (int i = 0; i < NUM_BLOCKS; i++)
                    begin
                        if (owner_tag[i] == tag)
                        begin
                            owner_tag[i] = FREE_TAG;
                            free_cnt++;
                            freed++;
                        end
                    end
                    r.freed_blocks = FREED_W'(freed);
                end
            end
            r.free_remaining = REMAIN_W'(free_cnt);
            pending.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [CLUS_W-1:0] clus,
                                   logic [FREED_W-1:0] freed, logic [REMAIN_W-1:0] remain);
            alloc_result_t want;
            alloc_result_t got;

            got.status         = st;
            got.cluster_count  = clus;
            got.freed_blocks   = freed;
            got.free_remaining = remain;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word st=%0d clus=%0d freed=%0d rem=%0d",
                             $realtime, st, clus, freed, remain);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("%0t: result %0d mismatch: status %0d/%0d clusters %0d/%0d ",
                           $realtime, checked, want.status, got.status,
                           want.cluster_count, got.cluster_count);
                    $display("freed %0d/%0d remaining %0d/%0d (expected/actual)",
                             want.freed_blocks, got.freed_blocks,
                             want.free_remaining, got.free_remaining);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = 1'b0;
    logic [LABEL_W-1:0]  file_label = '0;
    logic [NEED_W-1:0]   blocks_needed = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [CLUS_W-1:0]   cluster_count;
    logic [FREED_W-1:0]  freed_blocks;
    logic [REMAIN_W-1:0] free_remaining;

    int in_gap_max  = 10;
    int out_gap_max = 10;

    alloc_scoreboard sb = new();

    clustered_block_allocator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .file_label     (file_label),
        .blocks_needed  (blocks_needed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .cluster_count  (cluster_count),
        .freed_blocks   (freed_blocks),
        .free_remaining (free_remaining)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_500_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, cluster_count, freed_blocks, free_remaining);
    end

    // receiver: random stall before each result word
    initial
    begin : result_sink
        int gap;

        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Valid stays high across back-to-back words; it only drops when a gap is drawn.
    task automatic send_command(input cmd_t cmd, input logic [LABEL_W-1:0] label,
                                input logic [NEED_W-1:0] need);
        int gap;

        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        file_label    <= label;
        blocks_needed <= need;
        do @(posedge clk); while (in_stall);
        sb.note_command(cmd, label, need);
    endtask

    task automatic pick_idle_mode();
        case ($urandom_range(0, 4))
            0:
            begin
                in_gap_max  = 0;
                out_gap_max = 0;
            end
            1:
            begin
                in_gap_max  = 10;
                out_gap_max = 10;
            end
            2:
            begin
                in_gap_max  = 0;
                out_gap_max = 10;
            end
            3:
            begin
                in_gap_max  = 10;
                out_gap_max = 0;
            end
            default:
            begin
                in_gap_max  = 3;
                out_gap_max = 3;
            end
        endcase
    endtask

    initial
    begin : stimulus
        int                 done_items;
        int                 r;
        cmd_t               cmd;
        logic [LABEL_W-1:0] label;
        logic [NEED_W-1:0]  need;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero size, adds to an owner, holes, refusals, bad labels, full map
        send_command(CMD_ALLOC, 5'd0,  8'd0);
        send_command(CMD_ALLOC, 5'd0,  8'd5);
        send_command(CMD_ALLOC, 5'd1,  8'd3);
        send_command(CMD_ALLOC, 5'd0,  8'd2);
        send_command(CMD_FREE,  5'd1,  8'd255);
        send_command(CMD_ALLOC, 5'd2,  8'd6);
        send_command(CMD_FREE,  5'd7,  8'd0);
        send_command(CMD_ALLOC, 5'd26, 8'd4);
        send_command(CMD_ALLOC, 5'd31, 8'd255);
        send_command(CMD_FREE,  5'd31, 8'd0);
        send_command(CMD_ALLOC, 5'd25, 8'd255);
        send_command(CMD_ALLOC, 5'd3,  8'd129);
        send_command(CMD_FREE,  5'd0,  8'd0);
        send_command(CMD_FREE,  5'd2,  8'd0);
        send_command(CMD_ALLOC, 5'd25, 8'd128);
        send_command(CMD_ALLOC, 5'd4,  8'd1);
        send_command(CMD_ALLOC, 5'd4,  8'd0);
        send_command(CMD_FREE,  5'd25, 8'd170);
        send_command(CMD_ALLOC, 5'd24, 8'd129);
        send_command(CMD_ALLOC, 5'd5,  8'd128);
        send_command(CMD_FREE,  5'd5,  8'd85);

        done_items = 0;
        while (done_items < 1700)
        begin
            if (done_items % 150 == 0)
                pick_idle_mode();
            r     = $urandom_range(0, 99);
            label = $urandom_range(0, 1) ? LABEL_W'($urandom_range(0, 5))
                                         : LABEL_W'($urandom_range(0, 25));
            need  = NEED_W'($urandom_range(0, 255));
            if (r < 5)
            begin
                // noise: label outside the table
                cmd   = cmd_t'($urandom_range(0, 1));
                label = LABEL_W'($urandom_range(NUM_LABELS, 31));
            end
            else if (r < 10)
            begin
                cmd = CMD_ALLOC;
            end
            else if (r < ((sb.free_cnt < 20) ? 60 : 35))
            begin
                cmd = CMD_FREE;
            end
            else
            begin
                cmd = CMD_ALLOC;
                case ($urandom_range(0, 9))
                    0: need = '0;
                    1: need = NEED_W'(sb.free_cnt);
                    2: need = NEED_W'($urandom_range(0, sb.free_cnt));
                    default: need = NEED_W'($urandom_range(1, 12));
                endcase
            end
            send_command(cmd, label, need);
            done_items++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (NUM_BLOCKS + 8) @(posedge clk);

        $display("Ran %0d allocates (%0d of zero size, %0d refused), %0d frees, %0d ignored",
                 sb.n_alloc, sb.n_zero, sb.n_refused, sb.n_free, sb.n_ignored);
        $display("Checked %0d result words, most clusters in one allocate %0d, mismatches %0d",
                 sb.checked, sb.max_clusters, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
